FILE: rtl/bdr_pkg.sv
package bdr_pkg;

   localparam int NUM_BUTTONS   = 3;
   localparam int CFG_WIDTH     = 10;
   localparam int DIGIT_WIDTH   = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CFG_WIDTH-1:0] HOLD_DELAY_RESET      = 10'd300;
   localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_RESET = 10'd100;
   localparam logic                 PRESSED_LEVEL_RESET   = 1'b0;

   typedef logic [NUM_BUTTONS-1:0] levels_type;
   typedef logic [DIGIT_WIDTH-1:0] digit_type;

   localparam digit_type DIGIT_ZERO = 4'd0;
   localparam digit_type DIGIT_MAX  = 4'd9;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_HOLD_DELAY      = 2'd0;
   localparam csr_index_type CSR_REPEAT_INTERVAL = 2'd1;
   localparam csr_index_type CSR_PRESSED_LEVEL   = 2'd2;

   typedef struct packed {
      levels_type press_events;
      digit_type  count;
      digit_type  shown_digit;
      logic       show_valid;
   } result_type;

endpackage

FILE: rtl/bdr_stream_if.sv
interface bdr_req_if;
   import bdr_pkg::*;

   logic       valid;
   logic       ready;
   levels_type button_levels;

   modport source (output valid, output button_levels, input ready);
   modport sink (input valid, input button_levels, output ready);
endinterface

interface bdr_rsp_if;
   import bdr_pkg::*;

   logic       valid;
   logic       ready;
   levels_type press_events;
   digit_type  count;
   digit_type  shown_digit;
   logic       show_valid;

   modport source (output valid, output press_events, output count, output shown_digit,
                   output show_valid, input ready);
   modport sink (input valid, input press_events, input count, input shown_digit,
                 input show_valid, output ready);
endinterface

FILE: rtl/button_debounce_repeat_counter.sv
// Debounces three buttons, each needing three equal samples in a row, and
// drives a 0..9 counter with press and auto-repeat actions (button 0 clears,
// button 1 counts up, button 2 counts down). One scan tick is one req
// transfer and yields exactly one rsp transfer. A tick can be taken every
// clock cycle: it is latched in an input register, evaluated in one pass of
// per-button logic plus the counter chain, and written to a two-entry result
// queue, and its result is shown on rsp from the queue head. The queue lets
// one more tick in while a result waits; req stalls only when the input
// register holds a tick and both queue entries are occupied. Hold delay,
// repeat interval and the pressed level are APB registers at byte addresses
// 0, 4 and 8; delays load into TIMER_BITS-wide timers, masked.
module button_debounce_repeat_counter #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   bdr_req_if.sink                             req_ch,
   bdr_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bdr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bdr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import bdr_pkg::*;

   logic [CFG_WIDTH-1:0]  hold_delay_ff;
   logic [CFG_WIDTH-1:0]  repeat_interval_ff;
   logic                  pressed_level_ff;
   logic                  csr_write;
   csr_index_type         csr_index;

   logic                  in_valid_ff;
   levels_type            in_levels_ff;
   levels_type            hist1_ff;
   levels_type            hist2_ff;
   logic                  advance;
   logic                  out_space;
   logic [TIMER_BITS-1:0] hold_load;
   logic [TIMER_BITS-1:0] repeat_load;
   levels_type            fire;
   result_type            result;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      case (csr_index)
         CSR_HOLD_DELAY:      csr_prdata = CSR_DATA_BITS'(hold_delay_ff);
         CSR_REPEAT_INTERVAL: csr_prdata = CSR_DATA_BITS'(repeat_interval_ff);
         CSR_PRESSED_LEVEL:   csr_prdata = CSR_DATA_BITS'(pressed_level_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_delay_ff      <= HOLD_DELAY_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
         pressed_level_ff   <= PRESSED_LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HOLD_DELAY:      hold_delay_ff      <= csr_pwdata[CFG_WIDTH-1:0];
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_pwdata[CFG_WIDTH-1:0];
            CSR_PRESSED_LEVEL:   pressed_level_ff   <= csr_pwdata[0];
            default:             ;
         endcase
      end
   end

   // input register
   assign advance      = in_valid_ff && out_space;
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_levels_ff <= req_ch.button_levels;
      end
   end

   // sample history: hist1 is two ticks back, hist2 one tick back
   always_ff @(posedge clock) begin
      if (reset) begin
         hist1_ff <= {NUM_BUTTONS{~PRESSED_LEVEL_RESET}};
         hist2_ff <= {NUM_BUTTONS{~PRESSED_LEVEL_RESET}};
      end else if (advance) begin
         hist1_ff <= hist2_ff;
         hist2_ff <= in_levels_ff;
      end
   end

   assign hold_load   = TIMER_BITS'(hold_delay_ff);
   assign repeat_load = TIMER_BITS'(repeat_interval_ff);

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
      bdr_button #(
         .TIMER_BITS (TIMER_BITS)
      ) u_button (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .samples       ({in_levels_ff[b], hist2_ff[b], hist1_ff[b]}),
         .pressed_level (pressed_level_ff),
         .hold_load     (hold_load),
         .repeat_load   (repeat_load),
         .fire          (fire[b])
      );
   end

   bdr_action u_action (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fire    (fire),
      .result  (result)
   );

   bdr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (result),
      .has_space (out_space),
      .rsp_ch    (rsp_ch)
   );

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.count <= DIGIT_MAX))
      else $error("counter left the 0..9 range");

   a_show_matches_events: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.show_valid == (|rsp_ch.press_events)))
      else $error("show_valid disagrees with press_events");

   a_idle_shows_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.show_valid) |-> (rsp_ch.shown_digit == DIGIT_ZERO))
      else $error("digit shown without an action");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> in_valid_ff)
      else $error("accepted tick not held in the input register");

endmodule

FILE: rtl/bdr_button.sv
module bdr_button #(
   parameter int TIMER_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [2:0]            samples,
   input  logic                  pressed_level,
   input  logic [TIMER_BITS-1:0] hold_load,
   input  logic [TIMER_BITS-1:0] repeat_load,
   output logic                  fire
);
   import bdr_pkg::*;

   logic                  stable_ff;
   logic                  stable_in;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [TIMER_BITS-1:0] timer_in;
   logic [TIMER_BITS-1:0] timer_dec;
   logic                  settled;
   logic                  level;

   assign level     = samples[2];
   assign settled   = (samples[0] == samples[1]) && (samples[1] == samples[2]);
   assign timer_dec = timer_ff - TIMER_BITS'(1);

   always_comb begin
      stable_in = stable_ff;
      timer_in  = timer_ff;
      fire      = 1'b0;
      if (settled) begin
         if (stable_ff != level) begin
            // new stable level: a press fires and arms the hold delay
            stable_in = level;
            if (level == pressed_level) begin
               fire     = 1'b1;
               timer_in = hold_load;
            end
         end else if (timer_dec == '0) begin
            // timer ran out: repeat while held, reload either way
            fire     = (level == pressed_level);
            timer_in = repeat_load;
         end else begin
            timer_in = timer_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= ~PRESSED_LEVEL_RESET;
         timer_ff  <= TIMER_BITS'(HOLD_DELAY_RESET);
      end else if (advance) begin
         stable_ff <= stable_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

FILE: rtl/bdr_action.sv
module bdr_action (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  bdr_pkg::levels_type         fire,
   output bdr_pkg::result_type         result
);
   import bdr_pkg::*;

   digit_type counter_ff;
   digit_type counter_in;
   digit_type after_clear;
   digit_type after_inc;
   digit_type shown;

   always_comb begin
      // button 0 clears, then button 1 shows and increments, then button 2
      // shows and decrements
      after_clear = fire[0] ? DIGIT_ZERO : counter_ff;
      shown       = DIGIT_ZERO;
      after_inc   = after_clear;
      if (fire[1]) begin
         shown     = after_clear;
         after_inc = (after_clear >= DIGIT_MAX) ? DIGIT_ZERO : after_clear + 4'd1;
      end
      counter_in = after_inc;
      if (fire[2]) begin
         shown      = after_inc;
         counter_in = (after_inc == DIGIT_ZERO || after_inc > DIGIT_MAX) ?
                      DIGIT_MAX : after_inc - 4'd1;
      end
   end

   assign result.press_events = fire;
   assign result.count        = counter_in;
   assign result.shown_digit  = shown;
   assign result.show_valid   = |fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= DIGIT_ZERO;
      end else if (advance) begin
         counter_ff <= counter_in;
      end
   end

endmodule

FILE: rtl/bdr_out_buf.sv
module bdr_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bdr_pkg::result_type push_data,
   output logic                has_space,
   bdr_rsp_if.source           rsp_ch
);
   import bdr_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  fill_ff;
   logic        pop;
   result_type  head;

   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign has_space = (fill_ff != 2'd2);
   assign head      = entry_ff[rd_ptr_ff];

   assign rsp_ch.valid        = (fill_ff != 2'd0);
   assign rsp_ch.press_events = head.press_events;
   assign rsp_ch.count        = head.count;
   assign rsp_ch.shown_digit  = head.shown_digit;
   assign rsp_ch.show_valid   = head.show_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

FILE: bench/debounce_checker.sv
`timescale 1ns / 1ps

module debounce_checker #(
   parameter int TIMER_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   bdr_req_if                                req_ch,
   bdr_rsp_if                                rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [bdr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [bdr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                errors,
   output int                                outstanding,
   output int                                results_seen,
   output int                                action_ticks,
   output int                                repeat_fires
);
   import bdr_pkg::*;

   localparam int CLEAR_BUTTON = 0;
   localparam int UP_BUTTON    = 1;
   localparam int DOWN_BUTTON  = 2;

   typedef logic [TIMER_BITS-1:0] ticks_type;

   logic [CFG_WIDTH-1:0] hold_delay_q;
   logic [CFG_WIDTH-1:0] repeat_interval_q;
   logic                 pressed_q;

   levels_type history [3];
   levels_type stable;
   ticks_type  timer [NUM_BUTTONS];
   digit_type  counter;

   result_type pending_results [$];
   result_type want;

   initial begin
      errors       = 0;
      outstanding  = 0;
      results_seen = 0;
      action_ticks = 0;
      repeat_fires = 0;
   end

   function automatic void run_action(input int button, inout result_type r);
      r.press_events[button] = 1'b1;
      r.show_valid = 1'b1;
      case (button)
         CLEAR_BUTTON: begin
            r.shown_digit = DIGIT_ZERO;
            counter = DIGIT_ZERO;
         end
         UP_BUTTON: begin
            r.shown_digit = counter;
            counter = (counter >= DIGIT_MAX) ? DIGIT_ZERO : counter + 1'b1;
         end
         default: begin
            r.shown_digit = counter;
            counter = (counter == DIGIT_ZERO || counter > DIGIT_MAX) ? DIGIT_MAX
                                                                     : counter - 1'b1;
         end
      endcase
   endfunction

   // One scan tick: shift in the levels, then debounce and time each button in order.
   function automatic result_type scan_tick(input levels_type levels);
      result_type r;
      logic       level;
      r = '0;
      history[0] = history[1];
      history[1] = history[2];
      history[2] = levels;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (history[0][b] == history[1][b] && history[1][b] == history[2][b]) begin
            level = history[2][b];
            if (stable[b] != level) begin
               stable[b] = level;
               if (level == pressed_q) begin
                  run_action(b, r);
                  timer[b] = TIMER_BITS'(hold_delay_q);
               end
            end else begin
               // counts down while released too, wrapping from zero
               timer[b] = timer[b] - 1'b1;
               if (timer[b] == '0) begin
                  if (level == pressed_q) begin
                     run_action(b, r);
                     repeat_fires++;
                  end
                  timer[b] = TIMER_BITS'(repeat_interval_q);
               end
            end
         end
      end
      r.count = counter;
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         hold_delay_q      = HOLD_DELAY_RESET;
         repeat_interval_q = REPEAT_INTERVAL_RESET;
         pressed_q         = PRESSED_LEVEL_RESET;
         for (int i = 0; i < 3; i++) history[i] = {NUM_BUTTONS{~PRESSED_LEVEL_RESET}};
         stable = {NUM_BUTTONS{~PRESSED_LEVEL_RESET}};
         for (int b = 0; b < NUM_BUTTONS; b++) timer[b] = TIMER_BITS'(HOLD_DELAY_RESET);
         counter = DIGIT_ZERO;
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr >> 2))
               CSR_HOLD_DELAY:      hold_delay_q = csr_pwdata[CFG_WIDTH-1:0];
               CSR_REPEAT_INTERVAL: repeat_interval_q = csr_pwdata[CFG_WIDTH-1:0];
               CSR_PRESSED_LEVEL:   pressed_q = csr_pwdata[0];
               default: ;
            endcase
         end
         // predict before comparing so a same-cycle result would still line up
         if (req_ch.valid && req_ch.ready)
            pending_results.push_back(scan_tick(req_ch.button_levels));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no tick outstanding");
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("press_events", want.press_events, rsp_ch.press_events);
               check_field("count", want.count, rsp_ch.count);
               check_field("shown_digit", want.shown_digit, rsp_ch.shown_digit);
               check_field("show_valid", want.show_valid, rsp_ch.show_valid);
               results_seen++;
               if (want.show_valid) action_ticks++;
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

FILE: bench/tb_button_debounce_repeat_counter.sv
`timescale 1ns / 1ps

module tb_button_debounce_repeat_counter;
   import bdr_pkg::*;

   localparam csr_index_type CSR_UNMAPPED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam levels_type DIRECTED_TICKS [23] = '{
      3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0,
      3'd7, 3'd6, 3'd7, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd0, 3'd7
   };

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int errors;
   int outstanding;
   int results_seen;
   int action_ticks;
   int repeat_fires;
   int ticks_sent;
   int settings;
   int burst_left;
   bit squeeze;

   bdr_req_if req_ch ();
   bdr_rsp_if rsp_ch ();

   button_debounce_repeat_counter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   debounce_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .errors       (errors),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .action_ticks (action_ticks),
      .repeat_fires (repeat_fires)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("tb_button_debounce_repeat_counter: errors");
      $finish;
   end

   // Receiver: stall pattern in random stretches, plus one long hold-off on request.
   initial begin
      int  mode;
      int  stretch_left;
      bit  squeezed;
      mode = 0;
      stretch_left = 0;
      squeezed = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            squeezed = 1'b1;
         end else begin
            if (stretch_left == 0) begin
               mode = $urandom_range(0, 3);
               stretch_left = $urandom_range(20, 120);
            end
            stretch_left--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= $urandom_range(0, 1);
               default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   task automatic send_tick(input levels_type levels);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.button_levels <= levels;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
   endtask

   // Drop valid and wait for every outstanding result, then let the pipeline settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(index) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] hold,
                            input logic [CSR_DATA_BITS-1:0] interval,
                            input logic [CSR_DATA_BITS-1:0] level);
      drain();
      csr_write(CSR_HOLD_DELAY, hold);
      csr_write(CSR_REPEAT_INTERVAL, interval);
      csr_write(CSR_PRESSED_LEVEL, level);
      settings++;
   endtask

   // Held levels for random run lengths, with short broken runs and one-tick glitches.
   task automatic run_random(input int count, input int max_run);
      levels_type target;
      levels_type levels;
      int         run_left;
      target = '0;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            target = levels_type'($urandom_range(0, 7));
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, max_run);
         end
         run_left--;
         levels = target;
         if ($urandom_range(0, 99) < 6) levels = levels ^ levels_type'($urandom_range(1, 7));
         send_tick(levels);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.button_levels = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      ticks_sent = 0;
      settings = 1;
      burst_left = 0;
      squeeze = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_TICKS[i]) send_tick(DIRECTED_TICKS[i]);
      run_random(130, 400);

      configure(32'd1, 32'd1, 32'd1);
      run_random(220, 20);
      configure(32'd1023, 32'd1023, 32'd0);
      run_random(250, 120);
      // zero delays wrap the timer through its full range
      configure(32'd0, 32'd0, 32'd1);
      csr_write(CSR_UNMAPPED, $urandom);
      run_random(200, 40);
      // oversized values are masked to the register width
      configure(32'hFFFF_F805, 32'h0000_0C03, 32'hFFFF_FFFE);
      run_random(250, 40);
      for (int p = 0; p < 4; p++) begin
         configure($urandom_range(1, 30), $urandom_range(1, 15), $urandom_range(0, 1));
         if (p == 1) squeeze = 1'b1;
         run_random(220, 50);
      end
      drain();
      repeat (10) @(posedge clock);

      $display("%0d ticks sent, %0d results checked, %0d with an action, %0d auto-repeats",
               ticks_sent, results_seen, action_ticks, repeat_fires);
      $display("%0d register settings incl. zero, max and oversized delays, both polarities",
               settings);
      if (errors == 0) begin
         $display("tb_button_debounce_repeat_counter: clean");
      end else begin
         $display("tb_button_debounce_repeat_counter: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bdr_pkg.sv
rtl/bdr_stream_if.sv
rtl/bdr_button.sv
rtl/bdr_action.sv
rtl/bdr_out_buf.sv
rtl/button_debounce_repeat_counter.sv
bench/debounce_checker.sv
bench/tb_button_debounce_repeat_counter.sv
